// ----- hw/rtl/bee_pkg.sv -----
// Shared types and codes for the breakpoint envelope evaluator.
package bee_pkg;

    // Opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_EVAL   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    // Curve kinds
    localparam logic [2:0] CURVE_LINEAR = 3'd0;
    localparam logic [2:0] CURVE_SMOOTH = 3'd1;
    localparam logic [2:0] CURVE_STEP   = 3'd2;
    localparam logic [2:0] CURVE_EXP    = 3'd3;
    localparam logic [2:0] CURVE_LOG    = 3'd4;

    // Cell modes
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        time_beats;
        logic signed [31:0] point_value;
        logic [2:0]         curve_kind;
        logic [16:0]        curvature;
        logic [5:0]         point_index;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [6:0]         point_count;
    } t_out;

    typedef struct packed {
        logic [31:0]        time_beats;
        logic signed [31:0] value;
        logic [2:0]         curve;
        logic [16:0]        curvature;
    } t_point;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] query;
        t_point      entry;
    } t_cell_ctl;

    typedef struct packed {
        logic [31:0]        ta;
        logic [31:0]        dt;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic [2:0]         curve;
        logic [16:0]        curvature;
    } t_seg;

endpackage

// ----- hw/rtl/bee_cell.sv -----
// One breakpoint cell of the sorted table chain.
module bee_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic               i_clk,
    input  bee_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_count,
    input  logic [CW-1:0]      i_rm_index,
    input  bee_pkg::t_point    i_left,
    input  logic               i_left_le,
    input  bee_pkg::t_point    i_right,
    output bee_pkg::t_point    o_point,
    output logic               o_le
);
    import bee_pkg::*;

    t_point r_point;
    t_point n_point;

    // Flag an occupied cell whose time is at or before the query
    assign o_le    = (CW'(IDX) < i_count) && (r_point.time_beats <= i_ctl.query);
    assign o_point = r_point;

    // Pick the next content from the mode and the neighbors
    always_comb begin
        n_point = r_point;
        case (i_ctl.mode)
            CELL_INSERT: begin
                if (!o_le) begin
                    n_point = i_left_le ? i_ctl.entry : i_left;
                end
            end
            CELL_REMOVE: begin
                if (CW'(IDX) >= i_rm_index) begin
                    n_point = i_right;
                end
            end
            CELL_ROTATE: n_point = i_right;
            default:     n_point = r_point;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_point <= n_point;
    end

endmodule

// ----- hw/rtl/bee_shape.sv -----
// Segment fraction divider, curve shaping and final interpolation.
module bee_shape #(
    parameter int SHAPE_TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bee_pkg::t_seg      i_seg,
    output logic               o_done,
    output logic signed [31:0] o_result
);
    import bee_pkg::*;

    localparam int EW = $clog2(SHAPE_TABLE_ENTRIES + 1);
    localparam int PW = 16 + EW;
    localparam longint unsigned Q30 = 64'd1 << 30;

    typedef logic [16:0] t_rom [0:SHAPE_TABLE_ENTRIES];

    function automatic longint unsigned f_udiv(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned f_exp_q30(input longint unsigned y);
        longint unsigned term;
        longint unsigned sum;
        term = Q30;
        sum  = Q30;
        for (int k = 1; k <= 40; k++) begin
            term = f_udiv((term * y) >> 30, 64'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic longint unsigned f_ln_mant(input longint unsigned m);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned p;
        longint unsigned s;
        u  = f_udiv((m - Q30) << 30, m + Q30);
        u2 = (u * u) >> 30;
        p  = u;
        s  = 0;
        for (int j = 0; j < 25; j++) begin
            s = s + f_udiv(p, 64'(2 * j + 1));
            p = (p * u2) >> 30;
        end
        return 2 * s;
    endfunction

    function automatic longint unsigned f_ln_q30(input longint unsigned z);
        longint unsigned k;
        longint unsigned zz;
        k  = 0;
        zz = z;
        while (zz >= 2 * Q30) begin
            zz = zz >> 1;
            k  = k + 1;
        end
        return k * f_ln_mant(2 * Q30) + f_ln_mant(zz);
    endfunction

    function automatic logic [16:0] f_ratio(input longint unsigned num,
                                            input longint unsigned den);
        longint unsigned q;
        if (den == 0) begin
            return 17'd0;
        end
        q = f_udiv((num << 16) + (den >> 1), den);
        return q[16:0];
    endfunction

    function automatic t_rom f_build(input logic is_log);
        t_rom            rom;
        longint unsigned e2m1;
        longint unsigned ln10;
        longint unsigned y;
        longint unsigned z;
        e2m1 = f_exp_q30(2 * Q30) - Q30;
        ln10 = f_ln_q30(10 * Q30);
        for (int i = 0; i <= SHAPE_TABLE_ENTRIES; i++) begin
            if (is_log) begin
                z      = Q30 + f_udiv((64'(9 * i)) << 30, 64'(SHAPE_TABLE_ENTRIES));
                rom[i] = f_ratio(f_ln_q30(z), ln10);
            end else begin
                y      = f_udiv((64'(2 * i)) << 30, 64'(SHAPE_TABLE_ENTRIES));
                rom[i] = f_ratio(f_exp_q30(y) - Q30, e2m1);
            end
        end
        return rom;
    endfunction

    localparam t_rom ExpRom = f_build(1'b0);
    localparam t_rom LogRom = f_build(1'b1);

    localparam logic [3:0] SH_IDLE = 4'd0;
    localparam logic [3:0] SH_DIV  = 4'd1;
    localparam logic [3:0] SH_M1   = 4'd2;
    localparam logic [3:0] SH_M2   = 4'd3;
    localparam logic [3:0] SH_M3   = 4'd4;
    localparam logic [3:0] SH_M4   = 4'd5;
    localparam logic [3:0] SH_SEL  = 4'd6;
    localparam logic [3:0] SH_FMUL = 4'd7;
    localparam logic [3:0] SH_FADD = 4'd8;

    logic [3:0]         r_state;
    logic [4:0]         r_cnt;
    logic               r_done;
    t_seg               r_seg;
    logic [32:0]        r_rem;
    logic [16:0]        r_f;
    logic [33:0]        r_m1;
    logic [PW-1:0]      r_p;
    logic [16:0]        r_ss;
    logic [16:0]        r_ra;
    logic [16:0]        r_rb;
    logic [15:0]        r_frac;
    logic               r_ovf;
    logic [33:0]        r_pa;
    logic [33:0]        r_pb;
    logic [32:0]        r_prod;
    logic [16:0]        r_romv;
    logic [16:0]        r_s;
    logic [49:0]        r_qm;
    logic signed [31:0] r_res;

    logic [32:0]        w_rem_sh;
    logic               w_ge;
    logic [17:0]        w_tail;
    logic [51:0]        w_m2;
    logic [EW-1:0]      w_idx;
    logic [EW-1:0]      w_idx_hi;
    logic               w_idx_ovf;
    logic [16:0]        w_diff;
    logic [34:0]        w_blend;
    logic signed [32:0] w_d;
    logic [32:0]        w_mag;
    logic signed [33:0] w_delta;
    logic signed [33:0] w_sum;

    // Long division, one quotient bit a cycle
    assign w_rem_sh = (r_cnt == 5'd0) ? r_rem : {r_rem[31:0], 1'b0};
    assign w_ge     = w_rem_sh >= {1'b0, r_seg.dt};

    // Smoothstep tail term and table index
    assign w_tail    = 18'd196608 - {r_f, 1'b0};
    assign w_m2      = r_m1 * w_tail;
    assign w_idx     = r_p[PW-1:16];
    assign w_idx_ovf = w_idx >= EW'(SHAPE_TABLE_ENTRIES);
    assign w_idx_hi  = w_idx_ovf ? EW'(SHAPE_TABLE_ENTRIES) : w_idx + EW'(1);
    assign w_diff    = (r_rb >= r_ra) ? r_rb - r_ra : r_ra - r_rb;
    assign w_blend   = 35'(r_pa) + 35'(r_pb);

    // Signed span and its magnitude
    assign w_d     = 33'(r_seg.v2) - 33'(r_seg.v1);
    assign w_mag   = w_d[32] ? 33'(-w_d) : 33'(w_d);
    assign w_delta = w_d[32] ? -$signed({1'b0, r_qm[48:16]}) : $signed({1'b0, r_qm[48:16]});
    assign w_sum   = 34'(r_seg.v1) + w_delta;

    assign o_done   = r_done;
    assign o_result = r_res;

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SH_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= 5'd0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SH_IDLE: begin
                    if (i_start) begin
                        r_state <= SH_DIV;
                        r_cnt   <= 5'd0;
                    end
                end
                SH_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_state <= SH_M1;
                    end
                end
                SH_M1:   r_state <= SH_M2;
                SH_M2:   r_state <= SH_M3;
                SH_M3:   r_state <= SH_M4;
                SH_M4:   r_state <= SH_SEL;
                SH_SEL:  r_state <= SH_FMUL;
                SH_FMUL: r_state <= SH_FADD;
                SH_FADD: begin
                    r_state <= SH_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= SH_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            SH_IDLE: begin
                if (i_start) begin
                    r_seg <= i_seg;
                    r_rem <= {1'b0, i_seg.ta};
                    r_f   <= 17'd0;
                end
            end
            SH_DIV: begin
                r_rem <= w_ge ? w_rem_sh - {1'b0, r_seg.dt} : w_rem_sh;
                r_f   <= {r_f[15:0], w_ge};
            end
            SH_M1: begin
                r_m1 <= {17'd0, r_f} * {17'd0, r_f};
                r_p  <= {{(PW - 17){1'b0}}, r_f} * PW'(SHAPE_TABLE_ENTRIES);
            end
            SH_M2: begin
                r_ss   <= w_m2[48:32];
                r_ovf  <= w_idx_ovf;
                r_frac <= r_p[15:0];
                if (r_seg.curve == CURVE_LOG) begin
                    r_ra <= LogRom[w_idx];
                    r_rb <= LogRom[w_idx_hi];
                end else begin
                    r_ra <= ExpRom[w_idx];
                    r_rb <= ExpRom[w_idx_hi];
                end
            end
            SH_M3: begin
                r_pa   <= {17'd0, r_ss} * {17'd0, Q16_ONE - r_seg.curvature};
                r_prod <= {16'd0, w_diff} * {17'd0, r_frac};
            end
            SH_M4: begin
                r_pb <= {17'd0, r_f} * {17'd0, r_seg.curvature};
                if (r_ovf) begin
                    r_romv <= r_rb;
                end else if (r_rb >= r_ra) begin
                    r_romv <= r_ra + r_prod[32:16];
                end else begin
                    r_romv <= r_ra - r_prod[32:16];
                end
            end
            SH_SEL: begin
                case (r_seg.curve)
                    CURVE_SMOOTH: r_s <= w_blend[32:16];
                    CURVE_STEP:   r_s <= 17'd0;
                    CURVE_EXP:    r_s <= r_romv;
                    CURVE_LOG:    r_s <= r_romv;
                    default:      r_s <= r_f;
                endcase
            end
            SH_FMUL: r_qm <= w_mag * r_s;
            SH_FADD: r_res <= w_sum[31:0];
            default: r_res <= r_res;
        endcase
    end

endmodule

// ----- hw/rtl/breakpoint_envelope_evaluator.sv -----
// Breakpoint envelope evaluator: sorted point table chain, control and output word.
//
// Insert, remove and clear take effect at the edge that accepts the word. Their result
// word is held as the pending word in the put state until the output register is free.
// An evaluate word rotates the whole table of MAX_POINTS cells once past the head cells
// to find the spanning segment. A query at or outside the end points then answers from
// the head cells through the decide and put states. A query inside the table also runs
// a shift-subtract divider and a seven-step multiply sequence for the curve in the shape
// unit, and its result word is put out once that unit is done. An empty table answers
// like an insert. A new word is taken as soon as the previous one has finished, even
// while its result still waits downstream; if that earlier word is still held by an
// output stall when the new one finishes, the new one waits and the input stays
// stalled. The shape tables are built at elaboration; there is no clearing pass after
// reset.
module breakpoint_envelope_evaluator #(
    parameter int MAX_POINTS          = 64,
    parameter int SHAPE_TABLE_ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bee_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output bee_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_data
);
    import bee_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_POINTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [KW-1:0]      r_k;
    logic [31:0]        r_query;
    logic               r_clamp;
    logic signed [31:0] r_clamp_val;
    logic signed [31:0] r_default;
    t_seg               r_seg;
    t_out               r_pend;
    logic               r_ovalid;
    t_out               r_out;

    logic               w_acc;
    logic               w_full;
    logic               w_bad;
    logic [CW-1:0]      w_rm_index;
    logic [CW-1:0]      w_last;
    t_cell_ctl          w_ctl;
    t_point             w_pt [MAX_POINTS];
    logic               w_le [MAX_POINTS];
    logic               w_first_hit;
    logic               w_last_hit;
    logic               w_seg_hit;
    logic               w_load;
    logic               w_sh_done;
    logic signed [31:0] w_sh_res;

    assign w_acc      = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_full     = (r_count >= CW'(MAX_POINTS));
    assign w_bad      = ((CW + 6)'(i_data.point_index) >= (CW + 6)'(r_count));
    assign w_rm_index = CW'(i_data.point_index);
    assign w_last     = r_count - CW'(1);

    // Drive the cell chain
    always_comb begin
        w_ctl.mode              = CELL_HOLD;
        w_ctl.query             = (r_state == S_ROT) ? r_query : i_data.time_beats;
        w_ctl.entry.time_beats  = i_data.time_beats;
        w_ctl.entry.value       = i_data.point_value;
        w_ctl.entry.curve       = i_data.curve_kind;
        w_ctl.entry.curvature   = (i_data.curvature > Q16_ONE) ? Q16_ONE : i_data.curvature;
        if (r_state == S_ROT) begin
            w_ctl.mode = CELL_ROTATE;
        end else if (w_acc && i_data.opcode == OP_INSERT && !w_full) begin
            w_ctl.mode = CELL_INSERT;
        end else if (w_acc && i_data.opcode == OP_REMOVE && !w_bad) begin
            w_ctl.mode = CELL_REMOVE;
        end
    end

    for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
        localparam int LI = (gi + MAX_POINTS - 1) % MAX_POINTS;
        localparam int RI = (gi + 1) % MAX_POINTS;
        bee_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_rm_index (w_rm_index),
            .i_left     (w_pt[LI]),
            .i_left_le  ((gi == 0) ? 1'b1 : w_le[LI]),
            .i_right    (w_pt[RI]),
            .o_point    (w_pt[gi]),
            .o_le       (w_le[gi])
        );
    end

    // Watch the two head cells while the table rotates
    assign w_first_hit = (r_k == '0) && (r_query <= w_pt[0].time_beats);
    assign w_last_hit  = (CW'(r_k) == w_last) && (r_query >= w_pt[0].time_beats);
    assign w_seg_hit   = (CW'(r_k) < w_last) && (w_pt[0].time_beats < r_query)
                         && (w_pt[1].time_beats >= r_query);

    bee_shape #(
        .SHAPE_TABLE_ENTRIES (SHAPE_TABLE_ENTRIES)
    ) u_shape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == S_DEC) && !r_clamp),
        .i_seg    (r_seg),
        .o_done   (w_sh_done),
        .o_result (w_sh_res)
    );

    // Load the output word when it is free or being taken
    assign w_load = (r_state == S_PUT) && (!r_ovalid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_clamp   <= 1'b0;
            r_default <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_default <= i_cfg_data;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_PUT;
                        case (i_data.opcode)
                            OP_INSERT: begin
                                if (!w_full) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_REMOVE: begin
                                if (!w_bad) begin
                                    r_count <= r_count - CW'(1);
                                end
                            end
                            OP_CLEAR: r_count <= '0;
                            default: begin
                                if (r_count != '0) begin
                                    r_state <= S_ROT;
                                    r_k     <= '0;
                                    r_clamp <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_ROT: begin
                    r_k <= r_k + KW'(1);
                    if (!r_clamp && (w_first_hit || w_last_hit)) begin
                        r_clamp <= 1'b1;
                    end
                    if (r_k == KW'(MAX_POINTS - 1)) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC:   r_state <= r_clamp ? S_PUT : S_WAIT;
                S_WAIT: begin
                    if (w_sh_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload: query, segment capture, pending and output words
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_query             <= i_data.time_beats;
            r_pend.result_value <= '0;
            r_pend.status       <= ST_OK;
            case (i_data.opcode)
                OP_INSERT: begin
                    r_pend.status      <= w_full ? ST_FULL : ST_OK;
                    r_pend.point_count <= w_full ? 7'(r_count) : 7'(r_count + CW'(1));
                end
                OP_REMOVE: begin
                    r_pend.status      <= w_bad ? ST_BAD_INDEX : ST_OK;
                    r_pend.point_count <= w_bad ? 7'(r_count) : 7'(r_count - CW'(1));
                end
                OP_CLEAR: r_pend.point_count <= 7'd0;
                default: begin
                    r_pend.point_count  <= 7'(r_count);
                    r_pend.result_value <= r_default;
                end
            endcase
        end
        if (r_state == S_ROT) begin
            if (!r_clamp && (w_first_hit || w_last_hit)) begin
                r_clamp_val <= w_pt[0].value;
            end
            if (w_seg_hit) begin
                r_seg.ta        <= r_query - w_pt[0].time_beats;
                r_seg.dt        <= w_pt[1].time_beats - w_pt[0].time_beats;
                r_seg.v1        <= w_pt[0].value;
                r_seg.v2        <= w_pt[1].value;
                r_seg.curve     <= w_pt[0].curve;
                r_seg.curvature <= w_pt[0].curvature;
            end
        end
        if (r_state == S_DEC && r_clamp) begin
            r_pend.result_value <= r_clamp_val;
        end
        if (r_state == S_WAIT && w_sh_done) begin
            r_pend.result_value <= w_sh_res;
        end
        if (w_load) begin
            r_out <= r_pend;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule
